// ===== src/efu_pkg.sv =====
package efu_pkg;

  // latency of one pipelined 64x64 multiply
  localparam int MUL_LAT = 3;

  // fraction bits of the two rational paths
  localparam int SM_FB = 40;
  localparam int TL_FB = 30;

  // number of terms in the exponential series
  localparam int N_TERMS = 24;
  // rounded squarings after the series
  localparam int N_SQ = 7;

  localparam logic [31:0] HALF_Q27  = 32'd1 << 26;
  localparam logic [31:0] LIMIT_Q27 = 32'd1301911962;
  localparam logic [32:0] ONE_Q30   = 33'd1 << 30;
  localparam logic [32:0] TWO_Q30   = 33'd1 << 31;
  localparam logic [63:0] ONE_Q61   = 64'd1 << 61;
  localparam logic [63:0] TEN18     = 64'd1000000000000000000;

  typedef struct packed {
    logic [31:0] ip;
    logic [63:0] fr;
    logic        ng;
  } coef_t;

  localparam coef_t SMALL_NUM [7] = '{
    '{32'd80437, 64'd363096084017283216, 1'b0},
    '{32'd7404,  64'd71427101514700821,  1'b0},
    '{32'd3017,  64'd827885365075778092, 1'b0},
    '{32'd38,    64'd14031812390300824,  1'b0},
    '{32'd14,    64'd338384219174820558, 1'b0},
    '{32'd0,     64'd288805137207594085, 1'b1},
    '{32'd0,     64'd7547728033418631,   1'b0}
  };
  localparam coef_t SMALL_DEN [7] = '{
    '{32'd80437, 64'd363096084017282627, 1'b0},
    '{32'd34216, 64'd525792462853976901, 1'b0},
    '{32'd6379,  64'd600173244282794871, 1'b0},
    '{32'd658,   64'd70155459240506327,  1'b0},
    '{32'd38,    64'd19071395193940375,  1'b0},
    '{32'd1,     64'd0,                  1'b0},
    '{32'd0,     64'd0,                  1'b0}
  };
  localparam coef_t TAIL_NUM [9] = '{
    '{32'd1826,  64'd334884229511259217, 1'b0},
    '{32'd2898,  64'd29329216765561128,  1'b0},
    '{32'd2320,  64'd439590251635247385, 1'b0},
    '{32'd1143,  64'd262070703886173606, 1'b0},
    '{32'd368,   64'd519615471001063713, 1'b0},
    '{32'd77,    64'd81617303684286098,  1'b0},
    '{32'd9,     64'd675807882987265401, 1'b0},
    '{32'd0,     64'd564187782550739741, 1'b0},
    '{32'd0,     64'd0,                  1'b0}
  };
  localparam coef_t TAIL_DEN [9] = '{
    '{32'd1826,  64'd334884229511259558, 1'b0},
    '{32'd4958,  64'd827564721140714954, 1'b0},
    '{32'd6089,  64'd542423272443550463, 1'b0},
    '{32'd4429,  64'd612803883682726712, 1'b0},
    '{32'd2094,  64'd384367789539593790, 1'b0},
    '{32'd661,   64'd736120710765346921, 1'b0},
    '{32'd137,   64'd125596050062220288, 1'b0},
    '{32'd17,    64'd149809436276078494, 1'b0},
    '{32'd1,     64'd0,                  1'b0}
  };
  localparam coef_t KSCALE = '{32'd1, 64'd128379167095512574, 1'b0};

  // decimal fraction to binary fixed point, rounded to nearest; elaboration only
  function automatic logic [63:0] coef_q(coef_t c, int unsigned fb);
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] v;
    r = c.fr;
    q = '0;
    for (int unsigned k = 0; k < fb; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= TEN18) begin
        r = r - TEN18;
        q = q | 64'd1;
      end
    end
    if ((r << 1) >= TEN18) q = q + 64'd1;
    v = (64'(c.ip) << fb) + q;
    return c.ng ? (~v + 64'd1) : v;
  endfunction

endpackage

// ===== src/efu_mul.sv =====
module efu_mul #(
  parameter int SH  = 32,
  parameter bit RND = 1'b0,
  parameter bit SGN = 1'b0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [63:0] c,
  output logic [63:0] p
);
  localparam logic [127:0] RNDC = RND ? (128'd1 << (SH - 1)) : 128'd0;

  logic [63:0]  ua;
  logic [63:0]  pp_r [4];
  logic         s1_r, s2_r;
  logic [127:0] sum_nxt;
  logic [127:0] shf;
  logic [63:0]  m_r;
  logic [63:0]  p_r;
  logic [63:0]  p_nxt;

  // sign and magnitude for the signed form
  assign ua = (SGN && a[63]) ? (~a + 64'd1) : a;

  always_comb begin
    sum_nxt = {64'd0, pp_r[0]} + {32'd0, pp_r[1], 32'd0} + {32'd0, pp_r[2], 32'd0}
            + {pp_r[3], 64'd0} + RNDC;
    shf     = sum_nxt >> SH;
    p_nxt   = (s2_r ? (~m_r + 64'd1) : m_r) + c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[0] <= {32'd0, ua[31:0]}  * {32'd0, b[31:0]};
      pp_r[1] <= {32'd0, ua[31:0]}  * {32'd0, b[63:32]};
      pp_r[2] <= {32'd0, ua[63:32]} * {32'd0, b[31:0]};
      pp_r[3] <= {32'd0, ua[63:32]} * {32'd0, b[63:32]};
      s1_r    <= SGN && a[63];
      m_r     <= shf[63:0];
      s2_r    <= s1_r;
      p_r     <= p_nxt;
    end
  end

  assign p = p_r;
endmodule

// ===== src/efu_dly.sv =====
module efu_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[N-1];
endmodule

// ===== src/error_function_unit_core.sv =====
// erf / erfc unit, q5.27 argument in, q3.30 result out
// pipeline depth is set by the exponential path
// (24 series terms of 8 stages, 7 squarings, final product)
// throughput: one item per cycle; the whole pipeline holds while a result waits on out_tready
// reset: synchronous active-low rst_n clears every valid bit; data registers are not reset
module error_function_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] arg
  input  logic [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [32:0] value, [39:33] zero
);
  import efu_pkg::*;

  // stage offsets, counted from the squared-argument register
  localparam int HORN_SM   = 6 * MUL_LAT;
  localparam int DIV_SM_IN = HORN_SM + 1;               // after the clamp stage
  localparam int SM_RAT    = DIV_SM_IN + SM_FB + 2 + 1; // division steps plus rounding
  localparam int SM_OUT    = SM_RAT + MUL_LAT;
  localparam int TL_RAT    = 8 * MUL_LAT + TL_FB + 2 + 1;
  localparam int TERM_LAT  = 2 * MUL_LAT + 2;
  localparam int EX_T      = N_TERMS * TERM_LAT + 1;
  localparam int SQ_T      = EX_T + N_SQ * MUL_LAT;
  localparam int TL_OUT    = SQ_T + MUL_LAT;
  // input register, square register, the paths, two result stages
  localparam int VLD_N     = TL_OUT + 4;

  // global advance: every stage moves when the output slot is free or taken
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic [VLD_N-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VLD_N-2:0], in_tvalid};
    end
  end
  assign out_tvalid = vld_r[VLD_N-1];

  // stage 0: sign and magnitude
  logic [31:0] xm0_r, xm0_nxt;
  logic        neg0_r, cmd0_r;
  assign xm0_nxt = in_tdata[31] ? (~in_tdata + 32'd1) : in_tdata;

  // stage 1: x*x, exact in 64 bits
  logic [63:0] y1_r;
  logic [31:0] xm1_r;
  logic        neg1_r, cmd1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xm0_r  <= xm0_nxt;
      neg0_r <= in_tdata[31];
      cmd0_r <= in_tuser[0];
      y1_r   <= {32'd0, xm0_r} * {32'd0, xm0_r};
      xm1_r  <= xm0_r;
      neg1_r <= neg0_r;
      cmd1_r <= cmd0_r;
    end
  end

  // small path: horner in signed q40 on x^2
  logic [63:0] an_w [7];
  logic [63:0] ad_w [7];
  logic [63:0] ys_w [7];
  assign an_w[0] = coef_q(SMALL_NUM[6], SM_FB);
  assign ad_w[0] = coef_q(SMALL_DEN[6], SM_FB);
  assign ys_w[0] = y1_r;

  for (genvar j = 0; j < 6; j++) begin : g_shorn
    localparam logic [63:0] CN = coef_q(SMALL_NUM[5-j], SM_FB);
    localparam logic [63:0] CD = coef_q(SMALL_DEN[5-j], SM_FB);
    efu_mul #(.SH(54), .RND(1'b1), .SGN(1'b1)) u_mn (
      .clk(clk), .en(en), .a(an_w[j]), .b(ys_w[j]), .c(CN), .p(an_w[j+1])
    );
    efu_mul #(.SH(54), .RND(1'b1), .SGN(1'b1)) u_md (
      .clk(clk), .en(en), .a(ad_w[j]), .b(ys_w[j]), .c(CD), .p(ad_w[j+1])
    );
    efu_dly #(.W(64), .N(MUL_LAT)) u_y (.clk(clk), .en(en), .d(ys_w[j]), .q(ys_w[j+1]));
  end

  // negative numerator or denominator clamps to zero
  logic [63:0] snum_r, sden_r;
  always_ff @(posedge clk) begin
    if (en) begin
      snum_r <= an_w[6][63] ? 64'd0 : an_w[6];
      sden_r <= ad_w[6][63] ? 64'd0 : ad_w[6];
    end
  end

  // tail path: horner in unsigned q32 on x
  logic [63:0] tn_w [9];
  logic [63:0] td_w [9];
  logic [31:0] xt_w [9];
  assign tn_w[0] = coef_q(TAIL_NUM[8], 32);
  assign td_w[0] = coef_q(TAIL_DEN[8], 32);
  assign xt_w[0] = xm1_r;

  for (genvar j = 0; j < 8; j++) begin : g_thorn
    localparam logic [63:0] CN = coef_q(TAIL_NUM[7-j], 32);
    localparam logic [63:0] CD = coef_q(TAIL_DEN[7-j], 32);
    efu_mul #(.SH(27), .RND(1'b1), .SGN(1'b0)) u_mn (
      .clk(clk), .en(en), .a(tn_w[j]), .b({32'd0, xt_w[j]}), .c(CN), .p(tn_w[j+1])
    );
    efu_mul #(.SH(27), .RND(1'b1), .SGN(1'b0)) u_md (
      .clk(clk), .en(en), .a(td_w[j]), .b({32'd0, xt_w[j]}), .c(CD), .p(td_w[j+1])
    );
    efu_dly #(.W(32), .N(MUL_LAT)) u_x (.clk(clk), .en(en), .d(xt_w[j]), .q(xt_w[j+1]));
  end

  // restoring division, one quotient bit a stage; last bit rounds to nearest
  logic [63:0] dnum [2];
  logic [63:0] dden [2];
  logic [63:0] drat [2];
  assign dnum[0] = snum_r;
  assign dden[0] = sden_r;
  assign dnum[1] = tn_w[8];
  assign dden[1] = td_w[8];

  for (genvar g = 0; g < 2; g++) begin : g_div
    localparam int STEPS = (g == 0) ? SM_FB + 2 : TL_FB + 2;
    logic [63:0]      r_r [STEPS];
    logic [63:0]      d_r [STEPS];
    logic [STEPS-1:0] q_r [STEPS];
    logic [63:0]      rat_r;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [63:0]      rr, din;
      logic [STEPS-1:0] qin;
      logic             qb;
      if (i == 0) begin : g_first
        assign rr  = dnum[g];
        assign din = dden[g];
        assign qin = '0;
      end else begin : g_next
        assign rr  = {r_r[i-1][62:0], 1'b0};
        assign din = d_r[i-1];
        assign qin = q_r[i-1];
      end
      assign qb = rr >= din;
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[i] <= qb ? (rr - din) : rr;
          d_r[i] <= din;
          q_r[i] <= {qin[STEPS-2:0], qb};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) rat_r <= (64'(q_r[STEPS-1]) + 64'd1) >> 1;
    end
    assign drat[g] = rat_r;
  end

  // small path tail: scale by 2/sqrt(pi) times |x|, then by the ratio
  logic [63:0] ks_w, ks_d, small_w, small_d;
  efu_mul #(.SH(27), .RND(1'b1), .SGN(1'b0)) u_ks (
    .clk(clk), .en(en), .a(coef_q(KSCALE, SM_FB)), .b({32'd0, xm1_r}), .c(64'd0), .p(ks_w)
  );
  efu_dly #(.W(64), .N(SM_RAT - MUL_LAT)) u_ksd (.clk(clk), .en(en), .d(ks_w), .q(ks_d));
  efu_mul #(.SH(50), .RND(1'b1), .SGN(1'b0)) u_sm (
    .clk(clk), .en(en), .a(ks_d), .b(drat[0]), .c(64'd0), .p(small_w)
  );
  efu_dly #(.W(64), .N(TL_OUT - SM_OUT)) u_smd (
    .clk(clk), .en(en), .d(small_w), .q(small_d)
  );

  // exp(-x^2/128) by taylor series in q61; odd terms subtract
  logic [63:0] term_w [N_TERMS+1];
  logic [63:0] rr_w   [N_TERMS+1];
  logic [63:0] pos_w  [N_TERMS+1];
  logic [63:0] neg_w  [N_TERMS+1];
  assign term_w[0] = ONE_Q61;
  assign rr_w[0]   = y1_r;
  assign pos_w[0]  = ONE_Q61;
  assign neg_w[0]  = 64'd0;

  for (genvar t = 0; t < N_TERMS; t++) begin : g_term
    localparam int          K     = t + 1;
    localparam logic [63:0] K64   = 64'(K);
    localparam logic [64:0] RQ    = (65'd1 << 64) / K;
    // floor(2^64/k) estimate, one correction after; all ones for the first term
    localparam logic [63:0] RECIP = (K == 1) ? {64{1'b1}} : RQ[63:0];
    logic [63:0] t1_w, t1_d, q0_w, pos_d, neg_d, rem;
    logic [63:0] tc_r, tc_nxt, to_r, po_r, no_r;

    efu_mul #(.SH(61), .RND(1'b1), .SGN(1'b0)) u_tr (
      .clk(clk), .en(en), .a(term_w[t]), .b(rr_w[t]), .c(64'd0), .p(t1_w)
    );
    efu_mul #(.SH(64), .RND(1'b0), .SGN(1'b0)) u_rc (
      .clk(clk), .en(en), .a(t1_w), .b(RECIP), .c(64'd0), .p(q0_w)
    );
    efu_dly #(.W(64), .N(MUL_LAT)) u_t1 (.clk(clk), .en(en), .d(t1_w), .q(t1_d));
    efu_dly #(.W(64), .N(TERM_LAT - 1)) u_pd (.clk(clk), .en(en), .d(pos_w[t]), .q(pos_d));
    efu_dly #(.W(64), .N(TERM_LAT - 1)) u_nd (.clk(clk), .en(en), .d(neg_w[t]), .q(neg_d));
    efu_dly #(.W(64), .N(TERM_LAT)) u_rd (.clk(clk), .en(en), .d(rr_w[t]), .q(rr_w[t+1]));

    assign rem    = t1_d - q0_w * K64;
    assign tc_nxt = q0_w + ((rem >= K64) ? 64'd1 : 64'd0);

    always_ff @(posedge clk) begin
      if (en) begin
        tc_r <= tc_nxt;
        to_r <= tc_r;
        po_r <= (K % 2 == 1) ? pos_d : pos_d + tc_r;
        no_r <= (K % 2 == 1) ? neg_d + tc_r : neg_d;
      end
    end
    assign term_w[t+1] = to_r;
    assign pos_w[t+1]  = po_r;
    assign neg_w[t+1]  = no_r;
  end

  logic [63:0] ex_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ex_r <= (pos_w[N_TERMS] > neg_w[N_TERMS]) ? (pos_w[N_TERMS] - neg_w[N_TERMS]) : 64'd0;
    end
  end

  // raise to the 128th power by rounded squarings
  logic [63:0] sq_w [N_SQ+1];
  assign sq_w[0] = ex_r;
  for (genvar s = 0; s < N_SQ; s++) begin : g_sq
    efu_mul #(.SH(61), .RND(1'b1), .SGN(1'b0)) u_sq (
      .clk(clk), .en(en), .a(sq_w[s]), .b(sq_w[s]), .c(64'd0), .p(sq_w[s+1])
    );
  end

  logic [63:0] trat_d, tail_w;
  efu_dly #(.W(64), .N(SQ_T - TL_RAT)) u_trd (.clk(clk), .en(en), .d(drat[1]), .q(trat_d));
  // truncating product, flushes anything below 2^-30 to zero
  efu_mul #(.SH(61), .RND(1'b0), .SGN(1'b0)) u_tl (
    .clk(clk), .en(en), .a(sq_w[N_SQ]), .b(trat_d), .c(64'd0), .p(tail_w)
  );

  // argument side information travels alongside
  logic [33:0] side_d;
  efu_dly #(.W(34), .N(TL_OUT)) u_side (
    .clk(clk), .en(en), .d({cmd1_r, neg1_r, xm1_r}), .q(side_d)
  );

  // result stage 1: erfc of |x|, and which side of one half
  logic [32:0] emag_r, emag_nxt, sm2_r;
  logic        cmd2_r, neg2_r, le2_r;
  logic        lt_half, big;
  assign lt_half  = side_d[31:0] < HALF_Q27;
  assign big      = side_d[31:0] >= LIMIT_Q27;
  assign emag_nxt = lt_half ? (ONE_Q30 - small_d[32:0]) : (big ? 33'd0 : tail_w[32:0]);

  // result stage 2: sign handling for erf and reflection for erfc
  logic [32:0] val_r, val_nxt, erf_mag;
  assign erf_mag = le2_r ? sm2_r : (ONE_Q30 - emag_r);
  always_comb begin
    if (!cmd2_r) begin
      val_nxt = neg2_r ? (~erf_mag + 33'd1) : erf_mag;
    end else begin
      val_nxt = neg2_r ? (TWO_Q30 - emag_r) : emag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      emag_r <= emag_nxt;
      sm2_r  <= small_d[32:0];
      cmd2_r <= side_d[33];
      neg2_r <= side_d[32];
      le2_r  <= side_d[31:0] <= HALF_Q27;
      val_r  <= val_nxt;
    end
  end

  assign out_tdata = {7'd0, val_r};
endmodule

// ===== src/efu_chk.sv =====
module efu_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // input side only waits on a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready does not follow the output slot");

  // reset empties the pipeline
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid result after reset");

  // padding clear and negative results not below -1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[39:33] == 7'd0) &&
                   (!out_tdata[32] || (out_tdata[31:30] == 2'b11)))
    else $error("result out of range");
endmodule

bind error_function_unit_core efu_chk u_efu_chk (.*);

// ===== bench/error_function_unit_core_tb.sv =====
module error_function_unit_core_tb;
  import efu_pkg::*;

  // expected erf / erfc values in flight, with the fixed-point predictor
  class erf_scoreboard;
    logic [32:0] pending_values[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    // (a*b) >> s over a full 128-bit product, optionally rounded
    function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s, bit rnd);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      if (rnd) p = p + (128'd1 << (s - 1));
      return 64'(p >> s);
    endfunction

    function logic [63:0] smul_shift(logic [63:0] a, logic [63:0] b, int s);
      logic [63:0] ua;
      logic [63:0] p;
      ua = a[63] ? -a : a;
      p = mul_shift(ua, b, s, 1'b1);
      return a[63] ? -p : p;
    endfunction

    // rounded num * 2^fb / den by restoring division
    function logic [63:0] div_round(logic [63:0] num, logic [63:0] den, int fb);
      logic [63:0] q;
      logic [63:0] r;
      if (den == 64'd0) return 64'd0;
      q = num / den;
      r = num % den;
      for (int k = 0; k < fb; k++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 64'd1;
        end
      end
      if ((r << 1) >= den) q = q + 64'd1;
      return q;
    endfunction

    function logic [63:0] to_fixed(coef_t c, int fb);
      logic [63:0] v;
      v = (64'(c.ip) << fb) + div_round(c.fr, TEN18, fb);
      return c.ng ? -v : v;
    endfunction

    // erf magnitude in q30, |x| up to one half
    function logic [63:0] erf_small(logic [63:0] xm);
      logic [63:0] y;
      logic [63:0] an;
      logic [63:0] ad;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] t;
      y = xm * xm;
      an = to_fixed(SMALL_NUM[6], 40);
      ad = to_fixed(SMALL_DEN[6], 40);
      for (int k = 5; k >= 0; k--) begin
        an = smul_shift(an, y, 54) + to_fixed(SMALL_NUM[k], 40);
        ad = smul_shift(ad, y, 54) + to_fixed(SMALL_DEN[k], 40);
      end
      num = ($signed(an) > 0) ? an : 64'd0;
      den = ($signed(ad) > 0) ? ad : 64'd0;
      t = mul_shift(to_fixed(KSCALE, 40), xm, 27, 1'b1);
      return mul_shift(t, div_round(num, den, 40), 50, 1'b1);
    endfunction

    // erfc in q30 on the tail, via exp(-x*x/128)^128
    function logic [63:0] erfc_tail(logic [63:0] xm);
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] rat;
      logic [63:0] r;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] negs;
      logic [63:0] ex;
      num = to_fixed(TAIL_NUM[8], 32);
      den = to_fixed(TAIL_DEN[8], 32);
      for (int k = 7; k >= 0; k--) begin
        num = mul_shift(num, xm, 27, 1'b1) + to_fixed(TAIL_NUM[k], 32);
        den = mul_shift(den, xm, 27, 1'b1) + to_fixed(TAIL_DEN[k], 32);
      end
      rat = div_round(num, den, 30);
      r = xm * xm;
      term = ONE_Q61;
      pos = ONE_Q61;
      negs = 64'd0;
      for (int k = 1; k <= 24; k++) begin
        term = mul_shift(term, r, 61, 1'b1) / 64'(k);
        if (k % 2 == 1) negs = negs + term;
        else pos = pos + term;
      end
      ex = (pos > negs) ? pos - negs : 64'd0;
      for (int k = 0; k < 7; k++) ex = mul_shift(ex, ex, 61, 1'b1);
      return mul_shift(ex, rat, 61, 1'b0);
    endfunction

    function logic [63:0] erfc_mag(logic [63:0] xm);
      if (xm < 64'(HALF_Q27)) return 64'(ONE_Q30) - erf_small(xm);
      if (xm >= 64'(LIMIT_Q27)) return 64'd0;
      return erfc_tail(xm);
    endfunction

    function logic [32:0] erf_value(bit is_erfc, logic [31:0] arg);
      logic [63:0] xm;
      logic [63:0] mag;
      logic [63:0] res;
      xm = arg[31] ? (64'd1 << 32) - 64'(arg) : 64'(arg);
      if (!is_erfc) begin
        mag = (xm <= 64'(HALF_Q27)) ? erf_small(xm) : 64'(ONE_Q30) - erfc_mag(xm);
        res = arg[31] ? -mag : mag;
      end else begin
        res = arg[31] ? 64'(TWO_Q30) - erfc_mag(xm) : erfc_mag(xm);
      end
      return res[32:0];
    endfunction

    function void note_item(bit is_erfc, logic [31:0] arg);
      pending_values.push_back(erf_value(is_erfc, arg));
    endfunction

    function void check_item(logic [39:0] got);
      logic [32:0] want;
      if (pending_values.size() == 0) begin
        $display("%0t unexpected item: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_values.pop_front();
      if (got !== {7'd0, want}) begin
        $display("%0t value mismatch: expected %h, actual %h", $time, {7'd0, want}, got);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY    = 221;
  localparam int STALL_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] arg
  logic [0:0]  in_tuser;   // [0] cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [32:0] value, [39:33] zero

  erf_scoreboard sb;
  bit            calm;      // no idling on either side in the closing stretch
  int            quiet_cycles;

  error_function_unit_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sample both channels on the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_item(in_tuser[0], in_tdata);
      if (out_tvalid && out_tready) sb.check_item(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // result side back-pressure in bursts
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  // present one item, holding it until the block takes it
  task automatic send_item(bit is_erfc, logic [31:0] arg);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_erfc;
    in_tdata  <= arg;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_both(logic [31:0] arg);
    send_item(1'b0, arg);
    send_item(1'b1, arg);
  endtask

  // random argument shaped towards the interesting regions
  function automatic logic [31:0] pick_arg();
    logic [31:0] mag;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: mag = $urandom_range(0, 32'd1 << 26);                           // small path
      2: mag = $urandom_range((32'd1 << 26) - 64, (32'd1 << 26) + 64);   // near one half
      3: mag = $urandom_range(LIMIT_Q27 - 256, LIMIT_Q27 + 256);          // near the cut-off
      4: mag = $urandom_range(0, 64);                                     // tiny arguments
      default: mag = $urandom_range(0, 32'd11 << 27);                     // tail path
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  initial begin
    sb = new();
    calm = 1'b0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero, extremes, the half boundary, the large-argument cut-off
    send_both(32'd0);
    send_both(32'd1);
    send_both(32'hFFFF_FFFF);
    send_both(32'h7FFF_FFFF);
    send_both(32'h8000_0000);
    send_both(HALF_Q27);
    send_both(HALF_Q27 - 1);
    send_both(HALF_Q27 + 1);
    send_both(-HALF_Q27);
    send_both(LIMIT_Q27);
    send_both(LIMIT_Q27 - 1);
    send_both(-LIMIT_Q27);
    send_both(32'd1 << 27);

    for (int i = 0; i < 400; i++) begin
      if (i == 340) calm = 1'b1;
      send_item(1'($urandom_range(0, 1)), pick_arg());
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (sb.pending_values.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
